/* rtl/sms_pkg.sv */
`timescale 1ns / 1ps
// Shared types, register codes and helpers for the SPI master serializer.
// No dependencies; every rtl file imports this package.
package sms_pkg;

  localparam int WORD_BITS = 8;
  localparam int WAIT_W    = 16;
  localparam int BIT_IDX_W = $clog2(WORD_BITS);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SPI_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LSB_FIRST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_TICKS = 2'd2;

  localparam logic [WAIT_W-1:0] WAIT_TICKS_RST = 16'hFFFF;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WAIT1 = 2'd1,
    PH_WAIT2 = 2'd2
  } phase_t;

  typedef struct packed {
    logic                 operation;
    logic [WORD_BITS-1:0] tx_byte;
    logic                 last_byte;
    logic                 miso_level;
  } item_t;

  typedef struct packed {
    logic                 sck_level;
    logic                 mosi_level;
    logic                 cs_n_level;
    logic                 rx_valid;
    logic [WORD_BITS-1:0] rx_byte;
    logic                 busy_res;
  } result_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
  } cfg_wr_t;

  function automatic logic [WORD_BITS-1:0] flip_word(input logic [WORD_BITS-1:0] v);
    logic [WORD_BITS-1:0] r;
    for (int i = 0; i < WORD_BITS; i++) begin
      r[i] = v[WORD_BITS-1-i];
    end
    return r;
  endfunction

endpackage

/* rtl/sms_core.sv */
`timescale 1ns / 1ps
// Bit timing state, configuration registers and one-word step logic.
// Depends on sms_pkg; instantiated by spi_master_serializer_unit.
module sms_core
  import sms_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  item_t   item,
  input  cfg_wr_t cfg_wr,
  output result_t res
);

  logic [1:0]           spi_mode_r, spi_mode_nxt;
  logic                 lsb_first_r, lsb_first_nxt;
  logic [WAIT_W-1:0]    wait_ticks_r, wait_ticks_nxt;
  logic [WAIT_W-1:0]    wait_count_r, wait_count_nxt;
  logic [BIT_IDX_W-1:0] bit_index_r, bit_index_nxt;
  logic [WORD_BITS-1:0] tx_shift_r, tx_shift_nxt;
  logic [WORD_BITS-1:0] rx_shift_r, rx_shift_nxt;
  phase_t               phase_r, phase_nxt;
  logic                 clock_level_r, clock_level_nxt;
  logic                 select_active_r, select_active_nxt;
  logic                 release_after_r, release_after_nxt;
  logic                 mosi_r, mosi_nxt;

  logic [WAIT_W-1:0]    span;
  logic [WAIT_W-1:0]    cnt_inc;
  logic                 wait_hit;
  logic                 busy_now;
  logic                 cpha;
  logic                 cpol;
  logic [WORD_BITS-1:0] tx_load;
  logic [BIT_IDX_W-1:0] bit_dec;
  logic                 rx_valid;

  assign cpha     = spi_mode_r[0];
  assign cpol     = spi_mode_r[1];
  assign span     = (wait_ticks_r == '0) ? WAIT_W'(1) : wait_ticks_r;
  assign cnt_inc  = wait_count_r + WAIT_W'(1);
  assign wait_hit = (cnt_inc >= span);
  assign busy_now = (phase_r == PH_WAIT1) || (phase_r == PH_WAIT2);
  assign tx_load  = lsb_first_r ? flip_word(item.tx_byte) : item.tx_byte;
  assign bit_dec  = bit_index_r - BIT_IDX_W'(1);

  always_comb begin
    spi_mode_nxt      = spi_mode_r;
    lsb_first_nxt     = lsb_first_r;
    wait_ticks_nxt    = wait_ticks_r;
    wait_count_nxt    = wait_count_r;
    bit_index_nxt     = bit_index_r;
    tx_shift_nxt      = tx_shift_r;
    rx_shift_nxt      = rx_shift_r;
    phase_nxt         = phase_r;
    clock_level_nxt   = clock_level_r;
    select_active_nxt = select_active_r;
    release_after_nxt = release_after_r;
    mosi_nxt          = mosi_r;
    rx_valid          = 1'b0;

    if (step) begin
      if (item.operation == OP_LOAD) begin
        if (!busy_now) begin
          tx_shift_nxt      = tx_load;
          rx_shift_nxt      = '0;
          release_after_nxt = item.last_byte;
          select_active_nxt = 1'b1;
          clock_level_nxt   = cpol ^ cpha;
          bit_index_nxt     = BIT_IDX_W'(WORD_BITS - 1);
          mosi_nxt          = tx_load[WORD_BITS-1];
          wait_count_nxt    = '0;
          phase_nxt         = PH_WAIT1;
        end
      end else begin
        unique case (phase_r)
          PH_WAIT1: begin
            if (wait_hit) begin
              wait_count_nxt  = '0;
              clock_level_nxt = ~clock_level_r;
              phase_nxt       = PH_WAIT2;
            end else begin
              wait_count_nxt = cnt_inc;
            end
          end
          PH_WAIT2: begin
            if (wait_hit) begin
              wait_count_nxt = '0;
              rx_shift_nxt   = {rx_shift_r[WORD_BITS-2:0], item.miso_level};
              if (bit_index_r == '0) begin
                // last bit: only the CPHA=0 trailing edge applies
                clock_level_nxt = clock_level_r ^ ~cpha;
                rx_valid        = 1'b1;
                phase_nxt       = PH_IDLE;
                bit_index_nxt   = BIT_IDX_W'(WORD_BITS - 1);
                if (release_after_r) begin
                  select_active_nxt = 1'b0;
                end
              end else begin
                // trailing edge (CPHA=0) or leading edge (CPHA=1): one toggle
                clock_level_nxt = ~clock_level_r;
                bit_index_nxt   = bit_dec;
                mosi_nxt        = tx_shift_r[bit_dec];
                phase_nxt       = PH_WAIT1;
              end
            end else begin
              wait_count_nxt = cnt_inc;
            end
          end
          default: ;
        endcase
      end
    end

    if (cfg_wr.we) begin
      unique case (cfg_wr.index)
        CFG_SPI_MODE: begin
          spi_mode_nxt    = cfg_wr.data[1:0];
          clock_level_nxt = cfg_wr.data[1];
        end
        CFG_LSB_FIRST:  lsb_first_nxt  = cfg_wr.data[0];
        CFG_WAIT_TICKS: wait_ticks_nxt = cfg_wr.data[WAIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    res.sck_level  = clock_level_nxt;
    res.mosi_level = mosi_nxt;
    res.cs_n_level = ~select_active_nxt;
    res.rx_valid   = rx_valid;
    res.rx_byte    = rx_valid ? rx_shift_nxt : '0;
    res.busy_res   = (phase_nxt == PH_WAIT1) || (phase_nxt == PH_WAIT2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spi_mode_r      <= '0;
      lsb_first_r     <= 1'b0;
      wait_ticks_r    <= WAIT_TICKS_RST;
      wait_count_r    <= '0;
      bit_index_r     <= BIT_IDX_W'(WORD_BITS - 1);
      tx_shift_r      <= '0;
      rx_shift_r      <= '0;
      phase_r         <= PH_IDLE;
      clock_level_r   <= 1'b0;
      select_active_r <= 1'b0;
      release_after_r <= 1'b0;
      mosi_r          <= 1'b0;
    end else begin
      spi_mode_r      <= spi_mode_nxt;
      lsb_first_r     <= lsb_first_nxt;
      wait_ticks_r    <= wait_ticks_nxt;
      wait_count_r    <= wait_count_nxt;
      bit_index_r     <= bit_index_nxt;
      tx_shift_r      <= tx_shift_nxt;
      rx_shift_r      <= rx_shift_nxt;
      phase_r         <= phase_nxt;
      clock_level_r   <= clock_level_nxt;
      select_active_r <= select_active_nxt;
      release_after_r <= release_after_nxt;
      mosi_r          <= mosi_nxt;
    end
  end

  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && rx_valid |=> phase_r == PH_IDLE)
    else $error("phase not idle after completed word");

  a_idle_index: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> bit_index_r == BIT_IDX_W'(WORD_BITS - 1))
    else $error("bit index not rewound while idle");

  a_release_cs: assert property (@(posedge clk) disable iff (!rst_n)
    step && rx_valid && release_after_r |=> !select_active_r)
    else $error("chip select held after last word");

endmodule

/* rtl/spi_master_serializer_unit.sv */
`timescale 1ns / 1ps
// SPI master serializer top: input register, step logic, result register.
// An accepted word steps from the input register into the result register.
// Throughput: one word per clock; while out_stall holds the result register,
// the input register takes one more word and then stalls.
// Reset (rst_n low, synchronous) clears both stages, mode 0, wait 65535 ticks.
// Depends on sms_pkg and sms_core.
module spi_master_serializer_unit
  import sms_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_operation,
  input  logic [WORD_BITS-1:0] in_tx_byte,
  input  logic                 in_last_byte,
  input  logic                 in_miso_level,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_sck_level,
  output logic                 out_mosi_level,
  output logic                 out_cs_n_level,
  output logic                 out_rx_valid,
  output logic [WORD_BITS-1:0] out_rx_byte,
  output logic                 out_busy_res,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  logic    s1_valid_r, s1_valid_nxt;
  item_t   s1_item_r;
  logic    s2_valid_r, s2_valid_nxt;
  result_t s2_res_r;
  logic    s1_adv;
  logic    in_take;
  result_t core_res;
  cfg_wr_t cfg_wr;

  // advance the held word when the result register is free or draining
  assign s1_adv    = s1_valid_r && (!s2_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = !s1_valid_r && !s2_valid_r;

  assign cfg_wr.we    = cfg_valid && cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  assign s1_valid_nxt = in_take || (s1_valid_r && !s1_adv);
  assign s2_valid_nxt = s1_adv || (s2_valid_r && out_stall);

  sms_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_adv),
    .item   (s1_item_r),
    .cfg_wr (cfg_wr),
    .res    (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.operation  <= in_operation;
      s1_item_r.tx_byte    <= in_tx_byte;
      s1_item_r.last_byte  <= in_last_byte;
      s1_item_r.miso_level <= in_miso_level;
    end
    if (s1_adv) begin
      s2_res_r <= core_res;
    end
  end

  assign out_valid      = s2_valid_r;
  assign out_sck_level  = s2_res_r.sck_level;
  assign out_mosi_level = s2_res_r.mosi_level;
  assign out_cs_n_level = s2_res_r.cs_n_level;
  assign out_rx_valid   = s2_res_r.rx_valid;
  assign out_rx_byte    = s2_res_r.rx_byte;
  assign out_busy_res   = s2_res_r.busy_res;

  a_no_cfg_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr.we |-> !s1_adv)
    else $error("register write collided with a word step");

  a_word_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> s2_valid_r)
    else $error("stepped word missing from result register");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s2_valid_r && out_stall)
    else $error("input stalled with room downstream");

endmodule
